FILE: hdl/bitmap_font_glyph_placer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap font glyph placer
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FONT_GLYPH_PLACER_DEFINES_SVH
`define BITMAP_FONT_GLYPH_PLACER_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property, checked at every rising edge outside reset.
`define BFGP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication, checked at every rising edge outside reset.
`define BFGP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFGP_ASSERT(label, clk, rst_n, prop, msg)
`define BFGP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/bfgp_pkg.sv
// ---------------------------------------------------------------------------
// Glyph placer package
// Shared constants, codes and types of the bitmap font glyph placer.
// ---------------------------------------------------------------------------
package bfgp_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int COORD_BITS    = 16;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Divider retires DIV_STEP quotient bits per cycle.
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = (SLOT_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int SCALE_W   = 12;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 8 + SCALE_W;
  localparam int SCALED_W  = PROD_W - FRAC_BITS;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_WIDTH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CELL_WIDTH    = 3'd0,
    REG_LINE_HEIGHT   = 3'd1,
    REG_SHEET_COLUMNS = 3'd2,
    REG_FIRST_CODE    = 3'd3,
    REG_SCALE         = 3'd4,
    REG_TEXT_COLOR    = 3'd5,
    REG_SHEET_ID      = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_WIDTH,
    OP_NEWLINE,
    OP_SPACE,
    OP_GLYPH,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    logic [7:0]         cell_width;
    logic [7:0]         line_height;
    logic [7:0]         sheet_columns;
    logic [7:0]         first_code;
    logic [SCALE_W-1:0] scale_q4_8;
    logic [31:0]        text_color;
    logic [15:0]        sheet_id;
  } cfg_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [SLOT_BITS-1:0] slot;
    logic [15:0]          start_x;
    logic [15:0]          start_y;
    logic [7:0]           width;
  } q_entry_t;

  // Port coordinate (16-bit signed) into pen width.
  function automatic logic [COORD_BITS-1:0] coord_in(logic [15:0] v);
    logic signed [31:0] t;
    t = 32'(signed'(v));
    return t[COORD_BITS-1:0];
  endfunction

  // Pen coordinate into port width (sign extended or cut to 16 bits).
  function automatic logic [15:0] coord_out(logic [COORD_BITS-1:0] v);
    logic signed [31:0] t;
    t = 32'(signed'(v));
    return t[15:0];
  endfunction

endpackage

FILE: hdl/bfgp_in_if.sv
// ---------------------------------------------------------------------------
// Glyph placer input channel
// Valid/ready channel that carries one command item per transfer.
// ---------------------------------------------------------------------------
interface bfgp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         char_code;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [6:0]         entry_index;
  logic [7:0]         entry_width;

  modport source (
    output valid, cmd, char_code, start_x, start_y, entry_index, entry_width,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, start_x, start_y, entry_index, entry_width,
    output ready
  );
endinterface

FILE: hdl/bfgp_out_if.sv
// ---------------------------------------------------------------------------
// Glyph placer result channel
// Valid/ready channel that carries one placed glyph or error result per transfer.
// ---------------------------------------------------------------------------
interface bfgp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] draw_x;
  logic signed [15:0] draw_y;
  logic signed [16:0] rect_left;
  logic [15:0]        rect_top;
  logic signed [16:0] rect_right;
  logic [15:0]        rect_bottom;
  logic [15:0]        glyph_sheet;
  logic [31:0]        glyph_color;
  logic               bad_char;

  modport source (
    output valid, draw_x, draw_y, rect_left, rect_top, rect_right, rect_bottom,
           glyph_sheet, glyph_color, bad_char,
    input  ready
  );
  modport sink (
    input  valid, draw_x, draw_y, rect_left, rect_top, rect_right, rect_bottom,
           glyph_sheet, glyph_color, bad_char,
    output ready
  );
endinterface

FILE: hdl/bfgp_cfg.sv
// ---------------------------------------------------------------------------
// Glyph placer register file
// APB-style configuration registers with reset values and read back.
// ---------------------------------------------------------------------------
module bfgp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfgp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bfgp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bfgp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output bfgp_pkg::cfg_t                    cfg_o
);
  import bfgp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_width    <= 8'd16;
      cfg_r.line_height   <= 8'd16;
      cfg_r.sheet_columns <= 8'd16;
      cfg_r.first_code    <= 8'd32;
      cfg_r.scale_q4_8    <= SCALE_W'(256);
      cfg_r.text_color    <= 32'hFFFF_FFFF;
      cfg_r.sheet_id      <= 16'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_CELL_WIDTH:    cfg_r.cell_width    <= pwdata[7:0];
        REG_LINE_HEIGHT:   cfg_r.line_height   <= pwdata[7:0];
        REG_SHEET_COLUMNS: cfg_r.sheet_columns <= pwdata[7:0];
        REG_FIRST_CODE:    cfg_r.first_code    <= pwdata[7:0];
        REG_SCALE:         cfg_r.scale_q4_8    <= pwdata[SCALE_W-1:0];
        REG_TEXT_COLOR:    cfg_r.text_color    <= pwdata[31:0];
        REG_SHEET_ID:      cfg_r.sheet_id      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CELL_WIDTH:    prdata = {24'd0, cfg_r.cell_width};
      REG_LINE_HEIGHT:   prdata = {24'd0, cfg_r.line_height};
      REG_SHEET_COLUMNS: prdata = {24'd0, cfg_r.sheet_columns};
      REG_FIRST_CODE:    prdata = {24'd0, cfg_r.first_code};
      REG_SCALE:         prdata = CFG_DATA_W'(cfg_r.scale_q4_8);
      REG_TEXT_COLOR:    prdata = cfg_r.text_color;
      REG_SHEET_ID:      prdata = {16'd0, cfg_r.sheet_id};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hdl/bfgp_front.sv
// ---------------------------------------------------------------------------
// Glyph placer front end
// Accepts input items and sorts them into back-end operations.
// ---------------------------------------------------------------------------
module bfgp_front (
  bfgp_in_if.sink          in_ch,
  input  logic [7:0]       first_code_i,
  input  logic             q_ready_i,
  output logic             push_o,
  output bfgp_pkg::q_entry_t entry_o
);
  import bfgp_pkg::*;

  logic [8:0] diff;
  logic       in_table;
  logic       idx_ok;
  logic       keep;

  assign in_ch.ready = q_ready_i;
  assign push_o      = in_ch.valid && q_ready_i && keep;

  always_comb begin
    diff     = {1'b0, in_ch.char_code} - {1'b0, first_code_i};
    in_table = !diff[8] && ({1'b0, diff[7:0]} < 9'(TABLE_ENTRIES));
    idx_ok   = {2'b00, in_ch.entry_index} < 9'(TABLE_ENTRIES);

    entry_o.kind    = OP_GLYPH;
    entry_o.slot    = diff[SLOT_BITS-1:0];
    entry_o.start_x = in_ch.start_x;
    entry_o.start_y = in_ch.start_y;
    entry_o.width   = in_ch.entry_width;
    keep            = 1'b0;

    unique case (cmd_t'(in_ch.cmd))
      CMD_START: begin
        entry_o.kind = OP_START;
        keep         = 1'b1;
      end
      CMD_CHAR: begin
        keep = 1'b1;
        // A newline needs no slot, so it is checked before the table range.
        priority if (in_ch.char_code == CHAR_NEWLINE) entry_o.kind = OP_NEWLINE;
        else if (!in_table)                          entry_o.kind = OP_BAD;
        else if (in_ch.char_code == CHAR_SPACE)      entry_o.kind = OP_SPACE;
        else                                         entry_o.kind = OP_GLYPH;
      end
      CMD_WIDTH: begin
        entry_o.kind = OP_WIDTH;
        entry_o.slot = SLOT_BITS'(in_ch.entry_index);
        keep         = idx_ok;
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

FILE: hdl/bfgp_queue.sv
// ---------------------------------------------------------------------------
// Glyph placer operation queue
// Small FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`include "bitmap_font_glyph_placer_defines.svh"

module bfgp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  bfgp_pkg::q_entry_t   entry_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bfgp_pkg::q_entry_t   head_o
);
  import bfgp_pkg::*;

  q_entry_t          slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign ready_o = cnt_r != QCNT_W'(QDEPTH);
  assign valid_o = cnt_r != '0;
  assign head_o  = slots_r[rd_ptr_r];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= entry_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `BFGP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH), "queue count over depth")
  `BFGP_ASSERT(a_cnt_grow, clk, rst_n, (do_push && !do_pop) |=> (cnt_r == QCNT_W'($past(cnt_r) + 1'b1)), "queue count did not grow")
  `BFGP_ASSERT_IMPL(a_pop_valid, clk, rst_n, pop_i, valid_o, "back end popped an empty queue")

endmodule

FILE: hdl/bfgp_back.sv
// ---------------------------------------------------------------------------
// Glyph placer back end
// Holds the pen and the width table and turns operations into glyphs.
// ---------------------------------------------------------------------------
`include "bitmap_font_glyph_placer_defines.svh"

module bfgp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfgp_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  bfgp_pkg::q_entry_t   q_head_i,
  output logic                 q_pop_o,
  bfgp_out_if.source           out_ch
);
  import bfgp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_MUL, S_EMIT, S_ADV, S_BAD
  } state_t;

  state_t state_r;
  q_entry_t op_r;

  // Width table: memory plus one valid bit per entry, so reset reads zero.
  logic [7:0]               wmem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] wvalid_r;
  logic [7:0]               rd_data_r;
  logic                     rd_valid_r;
  logic                     wr_en;

  logic [COORD_BITS-1:0] pen_x_r;
  logic [COORD_BITS-1:0] pen_y_r;
  logic [COORD_BITS-1:0] origin_x_r;

  logic [7:0]          w_r;
  logic [SCALED_W-1:0] sw_r;
  logic [7:0]          rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [15:0]         colcw_r;
  logic [15:0]         rowlh_r;
  logic [8:0]          half_r;

  logic        out_valid_r;
  logic [15:0] out_draw_x_r;
  logic [15:0] out_draw_y_r;
  logic [16:0] out_left_r;
  logic [15:0] out_top_r;
  logic [16:0] out_right_r;
  logic [15:0] out_bottom_r;
  logic [15:0] out_sheet_r;
  logic [31:0] out_color_r;
  logic        out_bad_r;

  logic [7:0]        cols;
  logic [7:0]        w_rd;
  logic [PROD_W-1:0] prod_w;
  logic [PROD_W-1:0] prod_lh;
  logic [7:0]        rem_t;
  logic [DIV_W-1:0]  quo_t;
  logic [8:0]        sh_t;
  logic [8:0]        diff_u;
  logic [8:0]        half_u;
  logic [8:0]        half_nxt;
  logic [17:0]       left_sum;
  logic [16:0]       left_v;
  logic [16:0]       right_v;
  logic [15:0]       bottom_v;
  logic              out_free;
  logic              out_load;
  logic              div_ok;

  assign cols     = (cfg_i.sheet_columns == 8'd0) ? 8'd1 : cfg_i.sheet_columns;
  assign w_rd     = rd_valid_r ? rd_data_r : 8'd0;
  assign prod_w   = {{SCALE_W{1'b0}}, w_rd} * {8'd0, cfg_i.scale_q4_8};
  assign prod_lh  = {{SCALE_W{1'b0}}, cfg_i.line_height} * {8'd0, cfg_i.scale_q4_8};
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = ((state_r == S_EMIT) || (state_r == S_BAD)) && out_free;
  assign q_pop_o  = (state_r == S_IDLE) && q_valid_i;
  assign wr_en    = q_pop_o && (q_head_i.kind == OP_WIDTH);

  // Restoring division of the slot by the column count, DIV_STEP bits a cycle.
  always_comb begin
    rem_t = rem_r;
    quo_t = quo_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      sh_t  = {rem_t, quo_t[DIV_W-1]};
      quo_t = {quo_t[DIV_W-2:0], 1'b0};
      if (sh_t >= {1'b0, cols}) begin
        rem_t    = 8'(sh_t - {1'b0, cols});
        quo_t[0] = 1'b1;
      end else begin
        rem_t = sh_t[7:0];
      end
    end
  end

  // Centering offset (cell_width - w) / 2, rounded toward zero.
  always_comb begin
    diff_u   = {1'b0, cfg_i.cell_width} - {1'b0, w_r};
    half_u   = 9'(diff_u + {8'd0, diff_u[8]});
    half_nxt = {half_u[8], half_u[8:1]};
  end

  assign left_sum = {2'b00, colcw_r} + {{9{half_r[8]}}, half_r};
  assign left_v   = left_sum[16:0];
  assign right_v  = 17'(left_v + {9'd0, w_r});
  assign bottom_v = 16'(rowlh_r + {8'd0, cfg_i.line_height});
  assign div_ok   = (16'(quo_r) * 16'(cols) + 16'(rem_r)) == 16'(op_r.slot);

  always_ff @(posedge clk) begin
    if (wr_en) wmem[q_head_i.slot] <= q_head_i.width;
    rd_data_r  <= wmem[q_head_i.slot];
    rd_valid_r <= wvalid_r[q_head_i.slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wvalid_r    <= '0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      origin_x_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result replaces the old one in the same cycle it is taken.
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid_i) begin
            op_r <= q_head_i;
            unique case (q_head_i.kind)
              OP_START: begin
                pen_x_r    <= coord_in(q_head_i.start_x);
                origin_x_r <= coord_in(q_head_i.start_x);
                pen_y_r    <= coord_in(q_head_i.start_y);
              end
              OP_WIDTH: wvalid_r[q_head_i.slot] <= 1'b1;
              OP_NEWLINE: begin
                pen_x_r <= origin_x_r;
                pen_y_r <= pen_y_r + COORD_BITS'(prod_lh[PROD_W-1:FRAC_BITS]);
              end
              OP_SPACE, OP_GLYPH: state_r <= S_READ;
              OP_BAD:             state_r <= S_BAD;
              default: ;
            endcase
          end
        end
        S_READ: begin
          w_r       <= w_rd;
          sw_r      <= prod_w[PROD_W-1:FRAC_BITS];
          rem_r     <= '0;
          quo_r     <= DIV_W'(op_r.slot);
          div_cnt_r <= DIV_CNT_W'(DIV_CYCLES - 1);
          state_r   <= (op_r.kind == OP_SPACE) ? S_ADV : S_DIV;
        end
        S_DIV: begin
          rem_r     <= rem_t;
          quo_r     <= quo_t;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) state_r <= S_MUL;
        end
        S_MUL: begin
          colcw_r <= {8'd0, rem_r} * {8'd0, cfg_i.cell_width};
          rowlh_r <= 16'(quo_r) * {8'd0, cfg_i.line_height};
          half_r  <= half_nxt;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_draw_x_r <= coord_out(pen_x_r);
            out_draw_y_r <= coord_out(pen_y_r);
            out_left_r   <= left_v;
            out_top_r    <= rowlh_r;
            out_right_r  <= right_v;
            out_bottom_r <= bottom_v;
            out_sheet_r  <= cfg_i.sheet_id;
            out_color_r  <= cfg_i.text_color;
            out_bad_r    <= 1'b0;
            pen_x_r      <= pen_x_r + COORD_BITS'(sw_r);
            state_r      <= S_IDLE;
          end
        end
        S_ADV: begin
          pen_x_r <= pen_x_r + COORD_BITS'(sw_r);
          state_r <= S_IDLE;
        end
        S_BAD: begin
          if (out_free) begin
            out_draw_x_r <= '0;
            out_draw_y_r <= '0;
            out_left_r   <= '0;
            out_top_r    <= '0;
            out_right_r  <= '0;
            out_bottom_r <= '0;
            out_sheet_r  <= '0;
            out_color_r  <= '0;
            out_bad_r    <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.draw_x      = $signed(out_draw_x_r);
  assign out_ch.draw_y      = $signed(out_draw_y_r);
  assign out_ch.rect_left   = $signed(out_left_r);
  assign out_ch.rect_top    = out_top_r;
  assign out_ch.rect_right  = $signed(out_right_r);
  assign out_ch.rect_bottom = out_bottom_r;
  assign out_ch.glyph_sheet = out_sheet_r;
  assign out_ch.glyph_color = out_color_r;
  assign out_ch.bad_char    = out_bad_r;

  `BFGP_ASSERT_IMPL(a_rem_below_cols, clk, rst_n, state_r == S_MUL, rem_r < cols,
                    "division remainder not below column count")
  `BFGP_ASSERT_IMPL(a_div_exact, clk, rst_n, state_r == S_MUL, div_ok,
                    "quotient and remainder do not rebuild the slot")
  `BFGP_ASSERT(a_emit_loads, clk, rst_n,
               (state_r == S_EMIT && out_free) |=> (out_valid_r && !out_bad_r),
               "glyph result not loaded")

endmodule

FILE: hdl/bitmap_font_glyph_placer.sv
// ---------------------------------------------------------------------------
// Bitmap font glyph placer
// Variable-width text layout: pen tracking and font sheet rectangles.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Moves per transfer
//   in_ch     sink       valid/ready        one command (start, char, width)
//   out_ch    source     valid/ready        one placed glyph or error result
//   cfg_*     slave      APB, pready high   one 32-bit register write or read
//
// The front end takes one input transfer per cycle while the two-entry
// operation queue has room. The back end applies a start, a width write or
// a newline as it pops it. A space takes the registered width-table read
// and the pen advance, a character outside the table the error result, and
// a drawn glyph the width-table read, the column divider (four quotient
// bits per cycle), the cell multiply and the emit step. Reset is synchronous
// and active low; the width table has one valid bit per entry, so no
// clearing pass follows reset. A stalled result register holds the back end
// in its emit step while the queue keeps taking transfers until it is full.
//
module bitmap_font_glyph_placer (
  input  logic                              clk,
  input  logic                              rst_n,
  bfgp_in_if.sink                           in_ch,
  bfgp_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bfgp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bfgp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bfgp_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import bfgp_pkg::*;

  cfg_t     cfg;
  logic     push;
  q_entry_t entry;
  logic     q_ready;
  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;

  // Configuration registers; the user must write them only while the datapath is quiet (not enforced here).
  bfgp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  // The front end resolves the glyph slot and range check at accept time,
  // and drops commands with an unused command code before they reach the
  // queue; a width write cannot address past the table (seven-bit index).
  bfgp_front u_front (
    .in_ch        (in_ch),
    .first_code_i (cfg.first_code),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .entry_o      (entry)
  );

  bfgp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // The back end owns the pen, the line origin and the width table, and
  // applies operations strictly in queue order.
  bfgp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
